[hdl/bmf_pkg.sv]
// bmf_pkg: shared types, constants and the reciprocal table of the box mean filter
// used by bmf_line_store, bmf_divide and box_mean_filter_top; depends on nothing
`default_nettype none

package bmf_pkg;

  localparam int PIX_W     = 8;    // grey pixel width
  localparam int RAD_W     = 2;    // window radius register width
  localparam int FW_W      = 11;   // frame width register width
  localparam int FH_W      = 13;   // frame height register width
  localparam int CFG_W     = 13;   // config write data width
  localparam int CFG_A_W   = 2;    // config register index width
  localparam int CMP_W     = 13;   // width of position compares
  localparam int ROW_W     = 12;   // row counter width
  localparam int MAX_HEIGHT = 4096;
  localparam int D_W       = 3;    // window side minus one, up to 6
  localparam int CSUM_W    = 11;   // up to 7 pixels
  localparam int WSUM_W    = 14;   // up to 49 pixels
  localparam int RECIP_W   = 21;
  localparam int RECIP_SH  = 20;
  localparam int PROD_W    = WSUM_W + RECIP_W;

  // register indexes
  localparam logic [CFG_A_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic valid;  // a word occupies this stage
    logic res;    // the word yields a result
    logic last;   // final result of the frame
  } bmf_tag_t;

  // ceil(2^20 / (2r+1)^2); exact floor for every window sum that can occur
  function automatic logic [RECIP_W-1:0] recip(input logic [RAD_W-1:0] r);
    logic [RECIP_W-1:0] m;
    begin
      case (r)
        2'd0:    m = 21'd1048576;
        2'd1:    m = 21'd116509;
        2'd2:    m = 21'd41944;
        default: m = 21'd21400;
      endcase
      return m;
    end
  endfunction

endpackage

`default_nettype wire

[hdl/bmf_ram.sv]
// bmf_ram: generic simple dual port ram, one write and one registered read port
// depends on nothing
`default_nettype none

module bmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/bmf_line_store.sv]
// bmf_line_store: line store read-modify-write and vertical column sum
// depends on bmf_pkg and bmf_ram
`default_nettype none

module bmf_line_store #(
  parameter int MAX_RADIUS = 3,
  parameter int MAX_WIDTH  = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              adv,
  input  wire logic                              acc,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]      col,
  input  wire logic [$clog2(2*MAX_RADIUS)-1:0]   slot,
  input  wire logic [bmf_pkg::PIX_W-1:0]         pixel,
  input  wire logic [bmf_pkg::D_W-1:0]           dia,
  input  wire bmf_pkg::bmf_tag_t                 tag_in,
  output logic      [bmf_pkg::CSUM_W-1:0]        colsum,
  output bmf_pkg::bmf_tag_t                      tag_out
);
  import bmf_pkg::*;

  localparam int LANES  = 2 * MAX_RADIUS;
  localparam int WORD_W = LANES * PIX_W;
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int SW     = $clog2(2 * MAX_RADIUS);

  bmf_tag_t          s1_tag_r;
  logic [CW-1:0]     s1_col_r;
  logic [SW-1:0]     s1_slot_r;
  logic [PIX_W-1:0]  s1_pix_r;
  logic              s1_fwd_r;
  logic [WORD_W-1:0] wr_word_r;
  logic [WORD_W-1:0] ram_rdata;
  logic [WORD_W-1:0] rd_word;
  logic [WORD_W-1:0] new_word;
  logic [CSUM_W-1:0] colsum_nxt;
  logic [CSUM_W-1:0] colsum_r;
  bmf_tag_t          s2_tag_r;
  logic              wr_en;

  // one word per column holds all lines
  bmf_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WIDTH)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_col_r),
    .wdata (new_word),
    .re    (acc),
    .raddr (col),
    .rdata (ram_rdata)
  );

  assign wr_en   = adv && s1_tag_r.valid && (dia != '0);
  assign rd_word = s1_fwd_r ? wr_word_r : ram_rdata;

  always_comb begin
    colsum_nxt = CSUM_W'(s1_pix_r);
    new_word   = rd_word;
    for (int s = 0; s < LANES; s++) begin
      if (s < int'(dia)) begin
        colsum_nxt = colsum_nxt + CSUM_W'(rd_word[s*PIX_W +: PIX_W]);
      end
      if (SW'(s) == s1_slot_r) begin
        new_word[s*PIX_W +: PIX_W] = s1_pix_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
      s2_tag_r <= '0;
      s1_fwd_r <= 1'b0;
    end else if (adv) begin
      s1_tag_r <= tag_in;
      s2_tag_r <= s1_tag_r;
      if (acc) begin
        // same column written at the edge this read is issued
        s1_fwd_r <= wr_en && (s1_col_r == col);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_col_r  <= col;
      s1_slot_r <= slot;
      s1_pix_r  <= pixel;
    end
    if (wr_en) begin
      wr_word_r <= new_word;
    end
    if (adv) begin
      colsum_r <= colsum_nxt;
    end
  end

  assign colsum  = colsum_r;
  assign tag_out = s2_tag_r;

  a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    $past(acc) && $past(adv) && s1_fwd_r |-> $past(wr_en))
    else $error("forward taken without a write in the same cycle");

endmodule

`default_nettype wire

[hdl/bmf_divide.sv]
// bmf_divide: floor division of the window sum by the window area
// reciprocal multiply; depends on bmf_pkg
`default_nettype none

module bmf_divide (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        adv,
  input  wire logic [bmf_pkg::WSUM_W-1:0]  winsum,
  input  wire logic [bmf_pkg::RAD_W-1:0]   radius,
  input  wire bmf_pkg::bmf_tag_t           tag_in,
  output logic      [bmf_pkg::PIX_W-1:0]   mean,
  output bmf_pkg::bmf_tag_t                tag_out
);
  import bmf_pkg::*;

  logic [PROD_W-1:0] prod_r;
  bmf_tag_t          tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (adv) begin
      tag_r <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= PROD_W'(winsum) * PROD_W'(recip(radius));
    end
  end

  assign mean    = prod_r[RECIP_SH +: PIX_W];
  assign tag_out = tag_r;

  a_mean_fits: assert property (@(posedge clk) disable iff (!rst_n)
    tag_r.valid && tag_r.res |-> prod_r[PROD_W-1:RECIP_SH+PIX_W] == '0)
    else $error("mean exceeds pixel range");

endmodule

`default_nettype wire

[hdl/box_mean_filter_top.sv]
// box_mean_filter_top: streaming 2-d box mean filter over grey frames
// depends on bmf_pkg, bmf_line_store, bmf_divide (and bmf_ram below it)
`default_nettype none

// Pixels enter in raster order, one word per cycle. For each pixel that closes
// a square window of side 2r+1 lying wholly inside the frame, one word leaves
// with the floor mean of that window, taken for the window's centre pixel
// (r rows up and r columns left); border centres give no word. tlast marks the
// frame's final result. The block sustains one pixel per cycle; the only stall
// is back pressure on the output, which holds the whole pipeline. From input
// acceptance to a result word the registered steps are line store read, column
// sum and write back, window sum from the column history, reciprocal multiply,
// output register. The line store is one ram word per column holding 2*MAX_RADIUS
// lines, read once per pixel and written back once per pixel for a nonzero
// radius; a one-word forward covers a frame width of one. Store contents are
// undefined after reset and need no clearing pass, since a full frame position
// only reads rows it has written. Register writes (radius, width, height) take
// effect at once and belong between items with the pipeline drained.
module box_mean_filter_top #(
  parameter int MAX_RADIUS = 3,
  parameter int MAX_WIDTH  = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input stream
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [7:0]                   in_tdata,   // [7:0] pixel
  // result stream
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic      [7:0]                   out_tdata,  // [7:0] mean_value
  output logic                              out_tlast,  // last_of_frame
  // config writes
  input  wire logic                         cfg_we,
  input  wire logic [bmf_pkg::CFG_A_W-1:0]  cfg_addr,
  input  wire logic [bmf_pkg::CFG_W-1:0]    cfg_wdata
);
  import bmf_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int SW    = $clog2(2 * MAX_RADIUS);
  localparam int HD    = 2 * MAX_RADIUS;

  // config registers
  logic [RAD_W-1:0] radius_r;
  logic [FW_W-1:0]  fwidth_r;
  logic [FH_W-1:0]  fheight_r;

  // frame position
  logic [CW-1:0]    col_r;
  logic [ROW_W-1:0] row_r;
  logic [SW-1:0]    rmod_r [MAX_RADIUS];  // row mod 2(k+1) per radius

  logic [RAD_W-1:0] r_eff;
  logic [D_W-1:0]   dia;
  logic [CMP_W-1:0] w_eff, h_eff, col_p1, row_p1;
  logic             col_wrap, row_wrap;
  logic             adv, acc;
  logic             res_c, last_c;
  logic [SW-1:0]    slot;
  bmf_tag_t         tag_in;

  // pipeline between units
  logic [CSUM_W-1:0] colsum;
  bmf_tag_t          s2_tag;
  logic [PIX_W-1:0]  hist_r [HD];
  logic [WSUM_W-1:0] winsum_nxt;
  logic [WSUM_W-1:0] winsum_r;
  bmf_tag_t          s3_tag_r;
  logic [PIX_W-1:0]  mean;
  bmf_tag_t          s4_tag;
  logic [CSUM_W-1:0] hist_sum_r [HD];

  logic              out_valid_r;
  logic [PIX_W-1:0]  out_data_r;
  logic              out_last_r;

  // config decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= RAD_W'(1);
      fwidth_r  <= FW_W'(1024);
      fheight_r <= FH_W'(1024);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RADIUS: radius_r  <= cfg_wdata[RAD_W-1:0];
        REG_WIDTH:  fwidth_r  <= cfg_wdata[FW_W-1:0];
        REG_HEIGHT: fheight_r <= cfg_wdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry, saturated
  always_comb begin
    if (MAX_RADIUS < 3 && int'(radius_r) > MAX_RADIUS) begin
      r_eff = RAD_W'(MAX_RADIUS);
    end else begin
      r_eff = radius_r;
    end
    dia = {r_eff, 1'b0};

    if (fwidth_r == '0) begin
      w_eff = CMP_W'(1);
    end else if (int'(fwidth_r) > MAX_WIDTH) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = CMP_W'(fwidth_r);
    end

    if (fheight_r == '0) begin
      h_eff = CMP_W'(1);
    end else if (int'(fheight_r) > MAX_HEIGHT) begin
      h_eff = CMP_W'(MAX_HEIGHT);
    end else begin
      h_eff = fheight_r;
    end
  end

  // whole pipeline moves unless a result is held at the output
  assign adv       = !out_valid_r || out_tready;
  assign acc       = in_tvalid && adv;
  assign in_tready = adv;

  assign col_p1   = CMP_W'(col_r) + CMP_W'(1);
  assign row_p1   = CMP_W'(row_r) + CMP_W'(1);
  assign col_wrap = col_p1 >= w_eff;
  assign row_wrap = row_p1 >= h_eff;

  assign res_c  = (CMP_W'(row_r) >= CMP_W'(dia)) && (CMP_W'(col_r) >= CMP_W'(dia))
               && (CMP_W'(col_r) < w_eff) && (CMP_W'(row_r) < h_eff);
  assign last_c = (row_p1 == h_eff) && (col_p1 == w_eff);

  // line slot of the arriving row: row mod 2r
  always_comb begin
    slot = '0;
    for (int k = 0; k < MAX_RADIUS; k++) begin
      if (int'(r_eff) == k + 1) begin
        slot = rmod_r[k];
      end
    end
  end

  assign tag_in = '{valid: in_tvalid, res: res_c, last: last_c};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      for (int k = 0; k < MAX_RADIUS; k++) begin
        rmod_r[k] <= '0;
      end
    end else if (acc) begin
      if (col_wrap) begin
        col_r <= '0;
        if (row_wrap) begin
          row_r <= '0;
          for (int k = 0; k < MAX_RADIUS; k++) begin
            rmod_r[k] <= '0;
          end
        end else begin
          row_r <= row_r + ROW_W'(1);
          for (int k = 0; k < MAX_RADIUS; k++) begin
            if (int'(rmod_r[k]) == 2 * k + 1) begin
              rmod_r[k] <= '0;
            end else begin
              rmod_r[k] <= rmod_r[k] + SW'(1);
            end
          end
        end
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // stage 1-2: line store and column sum
  bmf_line_store #(.MAX_RADIUS(MAX_RADIUS), .MAX_WIDTH(MAX_WIDTH)) u_line (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .acc     (acc),
    .col     (col_r),
    .slot    (slot),
    .pixel   (in_tdata),
    .dia     (dia),
    .tag_in  (tag_in),
    .colsum  (colsum),
    .tag_out (s2_tag)
  );

  // window sum stage: add the previous 2r column sums of the history line
  always_comb begin
    winsum_nxt = WSUM_W'(colsum);
    for (int k = 0; k < HD; k++) begin
      if (k < int'(dia)) begin
        winsum_nxt = winsum_nxt + WSUM_W'(hist_sum_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_tag_r <= '0;
    end else if (adv) begin
      s3_tag_r <= s2_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      winsum_r <= winsum_nxt;
      if (s2_tag.valid) begin
        hist_sum_r[0] <= colsum;
        for (int k = 1; k < HD; k++) begin
          hist_sum_r[k] <= hist_sum_r[k-1];
        end
      end
    end
  end

  // hist_r mirrors the low byte of each column sum for debug visibility
  always_comb begin
    for (int k = 0; k < HD; k++) begin
      hist_r[k] = hist_sum_r[k][PIX_W-1:0];
    end
  end

  // divide stage: divide by window area
  bmf_divide u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .winsum  (winsum_r),
    .radius  (r_eff),
    .tag_in  (s3_tag_r),
    .mean    (mean),
    .tag_out (s4_tag)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s4_tag.valid && s4_tag.res;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= mean;
      out_last_r <= s4_tag.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_rmod_parity: assert property (@(posedge clk) disable iff (!rst_n)
    rmod_r[0][0] == row_r[0])
    else $error("row slot counter out of step with row counter");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    acc && last_c |=> col_r == '0 && row_r == '0)
    else $error("frame position not cleared after last pixel");

  a_hist_view: assert property (@(posedge clk) disable iff (!rst_n)
    $past(adv) && $past(s2_tag.valid) |-> hist_r[0] == $past(colsum[PIX_W-1:0]))
    else $error("column history did not take the new column sum");

endmodule

`default_nettype wire
